// ===== hdl/grid_ray_caster_unit_assert.svh =====
// assertion macros for the ray caster checker
// expect clk and arst_n in scope where they are used
`ifndef GRID_RAY_CASTER_UNIT_ASSERT_SVH
`define GRID_RAY_CASTER_UNIT_ASSERT_SVH

// same-cycle implication
`define GRCU_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ray caster check failed");

// next-cycle implication
`define GRCU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ray caster check failed");

`endif

// ===== hdl/grc_pkg.sv =====
// shared constants and types of the grid ray caster
// no dependencies
package grc_pkg;
	localparam int FRAC_BITS     = 16;
	localparam int MAP_WIDTH     = 16;
	localparam int MAP_HEIGHT    = 16;
	localparam int SCREEN_WIDTH  = 1080;
	localparam int SCREEN_HEIGHT = 720;

	localparam int POS_W   = 20;
	localparam int VEC_W   = 18;
	localparam int COL_W   = 11;
	localparam int CELL_W  = 4;
	localparam int DIST_W  = 22;
	localparam int TEX_W   = 16;
	localparam int ROW_W   = 16;
	localparam int CFG_IDX_W = 3;

	localparam int DIVD_W = 36;
	localparam int DIVS_W = 34;

	localparam logic [2:0] CFG_PLAYER_X = 3'd0;
	localparam logic [2:0] CFG_PLAYER_Y = 3'd1;
	localparam logic [2:0] CFG_DIR_X    = 3'd2;
	localparam logic [2:0] CFG_DIR_Y    = 3'd3;
	localparam logic [2:0] CFG_PLANE_X  = 3'd4;
	localparam logic [2:0] CFG_PLANE_Y  = 3'd5;

	localparam logic OP_ROW_WRITE = 1'b0;
	localparam logic OP_CAST      = 1'b1;

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [DIVS_W-1:0] divisor;
	} div_req_t;
endpackage

// ===== hdl/grc_in_if.sv =====
// input channel of the ray caster: handshake and item fields
// uses grc_pkg
interface grc_in_if;
	logic                        valid;
	logic                        ready;
	logic                        operation;
	logic [grc_pkg::COL_W-1:0]   column;
	logic [grc_pkg::CELL_W-1:0]  row_index;
	logic [grc_pkg::ROW_W-1:0]   row_cells;
	modport source (output valid, operation, column, row_index, row_cells, input ready);
	modport sink (input valid, operation, column, row_index, row_cells, output ready);
endinterface

// ===== hdl/grc_out_if.sv =====
// output channel of the ray caster: handshake and result fields
// uses grc_pkg
interface grc_out_if;
	logic                        valid;
	logic                        ready;
	logic [grc_pkg::COL_W-1:0]   column_out;
	logic [grc_pkg::DIST_W-1:0]  wall_distance;
	logic                        hit_side;
	logic [grc_pkg::CELL_W-1:0]  hit_cell_x;
	logic [grc_pkg::CELL_W-1:0]  hit_cell_y;
	logic [grc_pkg::TEX_W-1:0]   texture_u;
	logic signed [15:0]          wall_top;
	logic signed [15:0]          wall_bottom;
	logic                        left_map;
	modport source (output valid, column_out, wall_distance, hit_side, hit_cell_x, hit_cell_y,
		texture_u, wall_top, wall_bottom, left_map, input ready);
	modport sink (input valid, column_out, wall_distance, hit_side, hit_cell_x, hit_cell_y,
		texture_u, wall_top, wall_bottom, left_map, output ready);
endinterface

// ===== hdl/grc_divider.sv =====
// shared unsigned restoring divider, one quotient bit per cycle
// uses grc_pkg
module grc_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  grc_pkg::div_req_t             req,
	output logic                          done,
	output logic [grc_pkg::DIVD_W-1:0]    quot
);
	localparam int DW = grc_pkg::DIVD_W;
	localparam int SW = grc_pkg::DIVS_W;
	localparam int CW = $clog2(DW + 1);

	logic [CW-1:0] cnt_q;
	logic [SW:0]   rem_q;
	logic [DW-1:0] quot_q;
	logic [SW-1:0] divisor_q;
	logic          done_q;
	logic [SW:0]   trial;
	logic          qbit;

	assign trial = {rem_q[SW-1:0], quot_q[DW-1]};
	assign qbit  = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= CW'(DW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1))
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= '0;
			quot_q    <= req.dividend;
			divisor_q <= req.divisor;
		end else if (cnt_q != '0) begin
			rem_q  <= qbit ? (trial - {1'b0, divisor_q}) : trial;
			quot_q <= {quot_q[DW-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule

// ===== hdl/grc_map_mem.sv =====
// wall map memory, one row per entry, registered read
// rows never written read as open; uses grc_pkg
module grc_map_mem (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          we,
	input  logic [grc_pkg::CELL_W-1:0]    waddr,
	input  logic [grc_pkg::ROW_W-1:0]     wdata,
	input  logic [grc_pkg::CELL_W-1:0]    raddr,
	output logic [grc_pkg::ROW_W-1:0]     rdata
);
	localparam int DEPTH = grc_pkg::MAP_HEIGHT;

	logic [grc_pkg::ROW_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]          row_vld_q;
	logic [grc_pkg::ROW_W-1:0] rd_q;
	logic                      rd_vld_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (we)
				row_vld_q[waddr] <= 1'b1;
			rd_vld_q <= row_vld_q[raddr];
		end
	end

	assign rdata = rd_vld_q ? rd_q : '0;
endmodule

// ===== hdl/grid_ray_caster_unit.sv =====
// top level of the grid ray caster: config registers, cast sequencer, result register
// uses grc_pkg, grc_in_if, grc_out_if, grc_divider, grc_map_mem
//
// A row write item is taken in the idle state and gives no result. A cast item runs alone:
// the camera coordinate comes from a constant reciprocal multiply, the two step deltas
// and the slice height each take one pass of the shared serial divider (one quotient bit
// per cycle, skipped for a zero ray component or a zero distance), and each cell step of
// the grid walk has a state to step and a state for the map memory read, for up to 32
// steps. A cast waits in its last state while the output register still holds a result
// that was not taken; the next item can be taken as soon as the result sits in the
// output register.
module grid_ray_caster_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	grc_in_if.sink                          in_ch,
	grc_out_if.source                       out_ch,
	input  logic                            cfg_we,
	input  logic [grc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [grc_pkg::POS_W-1:0]       cfg_data
);
	localparam int F    = grc_pkg::FRAC_BITS;
	localparam int RW   = 22;
	localparam int DLW  = F + 12;
	localparam int SDW  = 34;
	localparam int CAMW = 20;
	localparam int SZW  = 22;
	localparam int DW   = grc_pkg::DIVD_W;
	localparam int SW   = grc_pkg::DIVS_W;

	// 2*column*2^F/SCREEN_WIDTH = column*2^14/135, exact for any 11-bit column
	// with the multiplier ceil(2^33/135) and a shift by 19
	localparam int CAM_MW = 26;
	localparam logic [CAM_MW-1:0] CAM_MUL = 26'd63629146;
	localparam int CAM_SH = 19;

	localparam logic [DLW-1:0] DELTA_MAX = '1;
	localparam logic [grc_pkg::DIST_W-1:0] DIST_MAX = '1;
	localparam logic [SZW-1:0] SIZE_CAP = SZW'(1 << 20);
	localparam logic [DW-1:0] SIZE_NUM =
		DW'(grc_pkg::SCREEN_HEIGHT * grc_pkg::SCREEN_HEIGHT) << F;
	localparam logic [DW-1:0] RECIP_NUM = DW'(1) << (2 * F);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CAM  = 4'd1;
	localparam logic [3:0] S_MUL  = 4'd2;
	localparam logic [3:0] S_RAY  = 4'd3;
	localparam logic [3:0] S_DXS  = 4'd4;
	localparam logic [3:0] S_DXW  = 4'd5;
	localparam logic [3:0] S_DYS  = 4'd6;
	localparam logic [3:0] S_DYW  = 4'd7;
	localparam logic [3:0] S_SIDE = 4'd8;
	localparam logic [3:0] S_STEP = 4'd9;
	localparam logic [3:0] S_TEST = 4'd10;
	localparam logic [3:0] S_DIST = 4'd11;
	localparam logic [3:0] S_DEN  = 4'd12;
	localparam logic [3:0] S_SZS  = 4'd13;
	localparam logic [3:0] S_SZW  = 4'd14;
	localparam logic [3:0] S_FIN  = 4'd15;

	// configuration
	logic [grc_pkg::POS_W-1:0]        px_q, py_q;
	logic signed [grc_pkg::VEC_W-1:0] dirx_q, diry_q, plx_q, ply_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q   <= 20'd524288;
			py_q   <= 20'd524288;
			dirx_q <= -18'sd65536;
			diry_q <= '0;
			plx_q  <= '0;
			ply_q  <= 18'sd65536;
		end else if (cfg_we) begin
			unique case (cfg_index)
				grc_pkg::CFG_PLAYER_X: px_q   <= cfg_data;
				grc_pkg::CFG_PLAYER_Y: py_q   <= cfg_data;
				grc_pkg::CFG_DIR_X:    dirx_q <= cfg_data[grc_pkg::VEC_W-1:0];
				grc_pkg::CFG_DIR_Y:    diry_q <= cfg_data[grc_pkg::VEC_W-1:0];
				grc_pkg::CFG_PLANE_X:  plx_q  <= cfg_data[grc_pkg::VEC_W-1:0];
				grc_pkg::CFG_PLANE_Y:  ply_q  <= cfg_data[grc_pkg::VEC_W-1:0];
				default: ;
			endcase
		end
	end

	logic [3:0] state_q;
	logic       in_acc;
	assign in_ch.ready = (state_q == S_IDLE);
	assign in_acc = in_ch.valid && in_ch.ready;

	// map memory
	logic                        mem_we;
	logic [grc_pkg::CELL_W-1:0]  mem_raddr;
	logic [grc_pkg::ROW_W-1:0]   mem_rdata;
	assign mem_we = in_acc && (in_ch.operation == grc_pkg::OP_ROW_WRITE);

	grc_map_mem u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.waddr  (in_ch.row_index),
		.wdata  (in_ch.row_cells),
		.raddr  (mem_raddr),
		.rdata  (mem_rdata)
	);

	// divider
	grc_pkg::div_req_t div_req;
	logic              div_done;
	logic [DW-1:0]     div_quot;

	grc_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	// cast datapath registers
	logic [grc_pkg::COL_W-1:0]   col_q;
	logic signed [CAMW-1:0]      cam_q;
	logic signed [37:0]          mpx_q, mpy_q;
	logic signed [RW-1:0]        rx_q, ry_q;
	logic [DLW-1:0]              ddx_q, ddy_q;
	logic [SDW-1:0]              sdx_q, sdy_q;
	logic [grc_pkg::CELL_W-1:0]  mx_q, my_q;
	logic                        side_q;
	logic [5:0]                  n_q;
	logic [grc_pkg::DIST_W-1:0]  dist_q;
	logic [SW-1:0]               den_q;
	logic signed [44:0]          wprod_q;
	logic [SZW-1:0]              size_q;
	logic                        hit_q;

	// combinational helpers
	logic [grc_pkg::COL_W+CAM_MW-1:0] cam_prod;
	logic signed [RW-1:0]  rx_c, ry_c;
	logic [RW-1:0]         arx, ary;
	logic [DLW-1:0]        dsat;
	logic [F:0]            fx_c, fy_c;
	logic                  step_x;
	logic                  oob;
	logic [grc_pkg::CELL_W-1:0] nmx, nmy;
	logic [SDW-1:0]        dist_raw;
	logic signed [SZW:0]   vtop, top_c, bot_c;
	logic [F-1:0]          frac_c, u_c;
	logic signed [15:0]    top16, bot16;

	assign cam_prod = (grc_pkg::COL_W+CAM_MW)'(col_q) * (grc_pkg::COL_W+CAM_MW)'(CAM_MUL);
	assign rx_c = RW'(dirx_q) + RW'(mpx_q >>> F);
	assign ry_c = RW'(diry_q) + RW'(mpy_q >>> F);
	assign arx  = rx_q[RW-1] ? -rx_q : rx_q;
	assign ary  = ry_q[RW-1] ? -ry_q : ry_q;
	assign dsat = (div_quot > DW'(DELTA_MAX)) ? DELTA_MAX : div_quot[DLW-1:0];
	assign fx_c = rx_q[RW-1] ? {1'b0, px_q[F-1:0]} : ((F+1)'(1 << F) - {1'b0, px_q[F-1:0]});
	assign fy_c = ry_q[RW-1] ? {1'b0, py_q[F-1:0]} : ((F+1)'(1 << F) - {1'b0, py_q[F-1:0]});

	// ties step in y; a zero component steps forward
	assign step_x = sdx_q < sdy_q;
	always_comb begin
		nmx = mx_q;
		nmy = my_q;
		oob = 1'b0;
		if (step_x) begin
			if (rx_q[RW-1]) begin
				oob = (mx_q == '0);
				nmx = mx_q - 1'b1;
			end else begin
				oob = (mx_q == '1);
				nmx = mx_q + 1'b1;
			end
		end else begin
			if (ry_q[RW-1]) begin
				oob = (my_q == '0);
				nmy = my_q - 1'b1;
			end else begin
				oob = (my_q == '1);
				nmy = my_q + 1'b1;
			end
		end
	end
	assign mem_raddr = nmy;

	assign dist_raw = side_q ? (sdy_q - SDW'(ddy_q)) : (sdx_q - SDW'(ddx_q));

	// slice rows, truncating halves toward zero
	assign vtop  = (SZW+1)'(grc_pkg::SCREEN_HEIGHT) - (SZW+1)'(size_q);
	assign top_c = $signed(vtop + (SZW+1)'(vtop[SZW])) >>> 1;
	assign bot_c = top_c + (SZW+1)'(size_q);
	assign top16 = (top_c < -(SZW+1)'(32768)) ? -16'sd32768 :
		(top_c > (SZW+1)'(32767)) ? 16'sd32767 : top_c[15:0];
	assign bot16 = (bot_c < -(SZW+1)'(32768)) ? -16'sd32768 :
		(bot_c > (SZW+1)'(32767)) ? 16'sd32767 : bot_c[15:0];

	// texture coordinate from the low bits of the wall point
	assign frac_c = (side_q ? px_q[F-1:0] : py_q[F-1:0]) + wprod_q[2*F-1:F];
	assign u_c = ((!side_q && rx_q[RW-1]) || (side_q && !ry_q[RW-1] && ry_q != '0)) ?
		frac_c : (F'(0) - frac_c);

	// output register
	logic out_free;
	assign out_free = !out_ch.valid || out_ch.ready;

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = RECIP_NUM;
		div_req.divisor  = SW'(arx);
		unique case (state_q)
			S_DXS: begin
				div_req.start   = (rx_q != '0);
				div_req.divisor = SW'(arx);
			end
			S_DYS: begin
				div_req.start   = (ry_q != '0);
				div_req.divisor = SW'(ary);
			end
			S_SZS: begin
				div_req.start    = (dist_q != '0);
				div_req.dividend = SIZE_NUM;
				div_req.divisor  = den_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_ch.valid <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free)
				out_ch.valid <= 1'b1;
			else if (out_ch.valid && out_ch.ready)
				out_ch.valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_acc && in_ch.operation == grc_pkg::OP_CAST) state_q <= S_CAM;
				S_CAM:  state_q <= S_MUL;
				S_MUL:  state_q <= S_RAY;
				S_RAY:  state_q <= S_DXS;
				S_DXS:  state_q <= div_req.start ? S_DXW : S_DYS;
				S_DXW:  if (div_done) state_q <= S_DYS;
				S_DYS:  state_q <= div_req.start ? S_DYW : S_SIDE;
				S_DYW:  if (div_done) state_q <= S_SIDE;
				S_SIDE: state_q <= S_STEP;
				S_STEP: begin
					if (n_q == 6'd32 || oob)
						state_q <= S_FIN;
					else
						state_q <= S_TEST;
				end
				S_TEST: state_q <= mem_rdata[mx_q] ? S_DIST : S_STEP;
				S_DIST: state_q <= S_DEN;
				S_DEN:  state_q <= S_SZS;
				S_SZS:  state_q <= div_req.start ? S_SZW : S_FIN;
				S_SZW:  if (div_done) state_q <= S_FIN;
				S_FIN:  if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				col_q <= in_ch.column;
				hit_q <= 1'b0;
			end
			S_CAM: cam_q <= CAMW'(cam_prod >> CAM_SH) - CAMW'(1 << F);
			S_MUL: begin
				mpx_q <= plx_q * cam_q;
				mpy_q <= ply_q * cam_q;
			end
			S_RAY: begin
				rx_q <= rx_c;
				ry_q <= ry_c;
			end
			S_DXS: if (rx_q == '0) ddx_q <= DELTA_MAX;
			S_DXW: if (div_done) ddx_q <= dsat;
			S_DYS: if (ry_q == '0) ddy_q <= DELTA_MAX;
			S_DYW: if (div_done) ddy_q <= dsat;
			S_SIDE: begin
				sdx_q <= SDW'(({{(DLW-1){1'b0}}, fx_c} * {{(F+1){1'b0}}, ddx_q}) >> F);
				sdy_q <= SDW'(({{(DLW-1){1'b0}}, fy_c} * {{(F+1){1'b0}}, ddy_q}) >> F);
				mx_q  <= px_q[grc_pkg::POS_W-1:F];
				my_q  <= py_q[grc_pkg::POS_W-1:F];
				n_q   <= '0;
			end
			S_STEP: begin
				n_q <= n_q + 1'b1;
				if (step_x) begin
					sdx_q  <= sdx_q + SDW'(ddx_q);
					side_q <= 1'b0;
				end else begin
					sdy_q  <= sdy_q + SDW'(ddy_q);
					side_q <= 1'b1;
				end
				mx_q <= nmx;
				my_q <= nmy;
			end
			S_TEST: if (mem_rdata[mx_q]) hit_q <= 1'b1;
			S_DIST: dist_q <= (dist_raw > SDW'(DIST_MAX)) ? DIST_MAX :
				dist_raw[grc_pkg::DIST_W-1:0];
			S_DEN: begin
				den_q   <= SW'(grc_pkg::SCREEN_WIDTH) * SW'(dist_q);
				wprod_q <= $signed({1'b0, dist_q}) * (side_q ? rx_q : ry_q);
			end
			S_SZS: if (dist_q == '0) size_q <= SIZE_CAP;
			S_SZW: if (div_done)
				size_q <= (div_quot > DW'(SIZE_CAP)) ? SIZE_CAP : div_quot[SZW-1:0];
			S_FIN: if (out_free) begin
				out_ch.column_out <= col_q;
				if (hit_q) begin
					out_ch.wall_distance <= dist_q;
					out_ch.hit_side      <= side_q;
					out_ch.hit_cell_x    <= mx_q;
					out_ch.hit_cell_y    <= my_q;
					out_ch.texture_u     <= u_c;
					out_ch.wall_top      <= top16;
					out_ch.wall_bottom   <= bot16;
					out_ch.left_map      <= 1'b0;
				end else begin
					out_ch.wall_distance <= DIST_MAX;
					out_ch.hit_side      <= 1'b0;
					out_ch.hit_cell_x    <= '0;
					out_ch.hit_cell_y    <= '0;
					out_ch.texture_u     <= '0;
					out_ch.wall_top      <= 16'(grc_pkg::SCREEN_HEIGHT / 2);
					out_ch.wall_bottom   <= 16'(grc_pkg::SCREEN_HEIGHT / 2);
					out_ch.left_map      <= 1'b1;
				end
			end
			default: ;
		endcase
	end
endmodule

// ===== hdl/grc_checker.sv =====
// port-level checks of the grid ray caster, bound to the top level
// uses grid_ray_caster_unit_assert.svh and grc_pkg
`include "grid_ray_caster_unit_assert.svh"

module grc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          in_operation,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          left_map,
	input logic [grc_pkg::DIST_W-1:0]    wall_distance,
	input logic                          hit_side,
	input logic signed [15:0]            wall_top,
	input logic signed [15:0]            wall_bottom
);
	`GRCU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(wall_distance))
	`GRCU_ASSERT_NEXT(a_cast_busy, in_valid && in_ready && in_operation == grc_pkg::OP_CAST, !in_ready)
	`GRCU_ASSERT_IMP(a_miss_fields, out_valid && left_map, wall_distance == '1 && !hit_side && wall_top == wall_bottom)
	`GRCU_ASSERT_IMP(a_slice_order, out_valid && !left_map, wall_top <= wall_bottom)
endmodule

bind grid_ray_caster_unit grc_checker u_grc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_ch.valid),
	.in_ready      (in_ch.ready),
	.in_operation  (in_ch.operation),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.left_map      (out_ch.left_map),
	.wall_distance (out_ch.wall_distance),
	.hit_side      (out_ch.hit_side),
	.wall_top      (out_ch.wall_top),
	.wall_bottom   (out_ch.wall_bottom)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// self-checking bench for grid_ray_caster_unit: map row loads and ray casts under random flow
// uses grc_pkg, grc_in_if, grc_out_if and the grid_ray_caster_unit rtl
module testbench;
	import grc_pkg::*;

	localparam int STALL_LIMIT = 6000;

	typedef struct {
		logic [COL_W-1:0]  column_out;
		logic [DIST_W-1:0] wall_distance;
		logic              hit_side;
		logic [CELL_W-1:0] hit_cell_x;
		logic [CELL_W-1:0] hit_cell_y;
		logic [TEX_W-1:0]  texture_u;
		logic [15:0]       wall_top;
		logic [15:0]       wall_bottom;
		logic              left_map;
	} wall_slice_t;

	class cast_scoreboard;
		logic [ROW_W-1:0] walls[MAP_HEIGHT];
		longint pos_x, pos_y, view_x, view_y, cam_x, cam_y;
		wall_slice_t pending[$];
		int errors;

		function void reset_state();
			foreach (walls[i]) walls[i] = '0;
			pos_x = 524288;
			pos_y = 524288;
			view_x = -65536;
			view_y = 0;
			cam_x = 0;
			cam_y = 65536;
			errors = 0;
		endfunction

		function longint vec18(logic [POS_W-1:0] v);
			logic signed [VEC_W-1:0] s;
			s = v[VEC_W-1:0];
			return longint'(s);
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] v);
			case (idx)
				CFG_PLAYER_X: pos_x = longint'(v);
				CFG_PLAYER_Y: pos_y = longint'(v);
				CFG_DIR_X: view_x = vec18(v);
				CFG_DIR_Y: view_y = vec18(v);
				CFG_PLANE_X: cam_x = vec18(v);
				CFG_PLANE_Y: cam_y = vec18(v);
				default: ;
			endcase
		endfunction

		function longint step_delta(longint r);
			longint q;
			if (r == 0) return (longint'(1) << 28) - 1;
			q = (longint'(1) << 32) / (r < 0 ? -r : r);
			return q > (longint'(1) << 28) - 1 ? (longint'(1) << 28) - 1 : q;
		endfunction

		function logic [15:0] clip16(longint v);
			if (v < -32768) v = -32768;
			if (v > 32767) v = 32767;
			return v[15:0];
		endfunction

		// computes the expected wall slice of an accepted cast, or loads a map row
		function void note(logic op, logic [COL_W-1:0] col, logic [CELL_W-1:0] ri,
				logic [ROW_W-1:0] cells);
			longint cam, rx, ry, ddx, ddy, mx, my, fx, fy, sdx, sdy, stx, sty;
			longint wall_dist, size, top, wpt, frac, u;
			int side;
			bit hit;
			wall_slice_t s;
			if (op == OP_ROW_WRITE) begin
				walls[ri] = cells;
				return;
			end
			side = 0;
			hit = 0;
			cam = ((longint'(col) * 2) <<< 16) / SCREEN_WIDTH - 65536;
			rx = view_x + ((cam_x * cam) >>> 16);
			ry = view_y + ((cam_y * cam) >>> 16);
			ddx = step_delta(rx);
			ddy = step_delta(ry);
			mx = pos_x >>> 16;
			my = pos_y >>> 16;
			fx = pos_x & 65535;
			fy = pos_y & 65535;
			stx = rx < 0 ? -1 : 1;
			sty = ry < 0 ? -1 : 1;
			sdx = ((rx < 0 ? fx : 65536 - fx) * ddx) >>> 16;
			sdy = ((ry < 0 ? fy : 65536 - fy) * ddy) >>> 16;
			for (int n = 0; n < MAP_WIDTH + MAP_HEIGHT; n++) begin
				if (sdx < sdy) begin
					sdx += ddx; mx += stx; side = 0;
				end else begin
					sdy += ddy; my += sty; side = 1;
				end
				if (mx < 0 || mx >= MAP_WIDTH || my < 0 || my >= MAP_HEIGHT) break;
				if (walls[my][mx]) begin
					hit = 1;
					break;
				end
			end
			s.column_out = col;
			if (!hit) begin
				s.wall_distance = 22'h3FFFFF;
				s.hit_side = 1'b0;
				s.hit_cell_x = '0;
				s.hit_cell_y = '0;
				s.texture_u = '0;
				s.wall_top = clip16(SCREEN_HEIGHT / 2);
				s.wall_bottom = clip16(SCREEN_HEIGHT / 2);
				s.left_map = 1'b1;
			end else begin
				wall_dist = side == 0 ? sdx - ddx : sdy - ddy;
				if (wall_dist > 4194303) wall_dist = 4194303;
				if (wall_dist == 0) size = longint'(1) << 20;
				else begin
					size = ((longint'(SCREEN_HEIGHT) * SCREEN_HEIGHT) <<< 16)
						/ (longint'(SCREEN_WIDTH) * wall_dist);
					if (size > (longint'(1) << 20)) size = longint'(1) << 20;
				end
				top = (SCREEN_HEIGHT - size) / 2;
				if (side == 0) wpt = pos_y + ((wall_dist * ry) >>> 16);
				else wpt = pos_x + ((wall_dist * rx) >>> 16);
				frac = wpt & 65535;
				if ((side == 0 && rx < 0) || (side == 1 && ry > 0)) u = frac;
				else u = (65536 - frac) & 65535;
				s.wall_distance = wall_dist[DIST_W-1:0];
				s.hit_side = side[0];
				s.hit_cell_x = mx[CELL_W-1:0];
				s.hit_cell_y = my[CELL_W-1:0];
				s.texture_u = u[TEX_W-1:0];
				s.wall_top = clip16(top);
				s.wall_bottom = clip16(top + size);
				s.left_map = 1'b0;
			end
			pending.push_back(s);
		endfunction

		function void field(string name, longint exp, longint act);
			if (exp != act) begin
				$error("%s: expected %0d, got %0d", name, exp, act);
				errors++;
			end
		endfunction

		function void check(wall_slice_t got);
			wall_slice_t e;
			if (pending.size() == 0) begin
				$error("unexpected result for column %0d", got.column_out);
				errors++;
				return;
			end
			e = pending.pop_front();
			field("column_out", e.column_out, got.column_out);
			field("wall_distance", e.wall_distance, got.wall_distance);
			field("hit_side", e.hit_side, got.hit_side);
			field("hit_cell_x", e.hit_cell_x, got.hit_cell_x);
			field("hit_cell_y", e.hit_cell_y, got.hit_cell_y);
			field("texture_u", e.texture_u, got.texture_u);
			field("wall_top", $signed(e.wall_top), $signed(got.wall_top));
			field("wall_bottom", $signed(e.wall_bottom), $signed(got.wall_bottom));
			field("left_map", e.left_map, got.left_map);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [POS_W-1:0] cfg_data;
	bit idling;
	int quiet_cycles;

	grc_in_if in_ch();
	grc_out_if out_ch();
	cast_scoreboard slices;

	grid_ray_caster_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		slices = new();
		slices.reset_state();
	end

	// result side: check accepted items, stall ready in bursts
	initial begin
		int stall;
		wall_slice_t got;
		stall = 0;
		out_ch.ready = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready) begin
				got.column_out = out_ch.column_out;
				got.wall_distance = out_ch.wall_distance;
				got.hit_side = out_ch.hit_side;
				got.hit_cell_x = out_ch.hit_cell_x;
				got.hit_cell_y = out_ch.hit_cell_y;
				got.texture_u = out_ch.texture_u;
				got.wall_top = out_ch.wall_top;
				got.wall_bottom = out_ch.wall_bottom;
				got.left_map = out_ch.left_map;
				slices.check(got);
			end
			if (stall > 0) begin
				stall--;
				out_ch.ready <= 0;
			end else if (idling && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 17) - 1;
				out_ch.ready <= 0;
			end else begin
				out_ch.ready <= 1;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("grid_ray_caster_unit test failed");
			$finish;
		end
	end

	task automatic send_item(logic op, logic [COL_W-1:0] col, logic [CELL_W-1:0] ri,
			logic [ROW_W-1:0] cells);
		if (idling && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.operation <= op;
		in_ch.column <= col;
		in_ch.row_index <= ri;
		in_ch.row_cells <= cells;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		slices.note(op, col, ri, cells);
	endtask

	task automatic cast(logic [COL_W-1:0] col);
		send_item(OP_CAST, col, 4'($urandom), 16'($urandom));
	endtask

	task automatic load_row(logic [CELL_W-1:0] ri, logic [ROW_W-1:0] cells);
		send_item(OP_ROW_WRITE, 11'($urandom), ri, cells);
	endtask

	// let the block drain before touching the registers
	task automatic drain();
		in_ch.valid <= 0;
		@(posedge clk);
		while (slices.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		slices.set_reg(idx, v);
	endtask

	task automatic set_view(logic [POS_W-1:0] px, logic [POS_W-1:0] py, logic [POS_W-1:0] vx,
			logic [POS_W-1:0] vy, logic [POS_W-1:0] cx, logic [POS_W-1:0] cy);
		write_reg(CFG_PLAYER_X, px);
		write_reg(CFG_PLAYER_Y, py);
		write_reg(CFG_DIR_X, vx);
		write_reg(CFG_DIR_Y, vy);
		write_reg(CFG_PLANE_X, cx);
		write_reg(CFG_PLANE_Y, cy);
	endtask

	function automatic logic [POS_W-1:0] rand_vec();
		case ($urandom_range(0, 5))
			0: return 20'h20000 | (20'($urandom) & 20'hC0000);
			1: return 20'h1FFFF | (20'($urandom) & 20'hC0000);
			2: return 20'($urandom) & 20'hC0000;
			default: return 20'($urandom);
		endcase
	endfunction

	function automatic logic [POS_W-1:0] rand_pos();
		case ($urandom_range(0, 4))
			0: return 20'h00000;
			1: return 20'hFFFFF;
			2: return 20'($urandom) & 20'hF0000;
			default: return 20'($urandom);
		endcase
	endfunction

	task automatic boxed_map();
		for (int r = 0; r < MAP_HEIGHT; r++)
			if (r == 0 || r == MAP_HEIGHT - 1) load_row(4'(r), 16'hFFFF);
			else load_row(4'(r), 16'h8001 | (16'($urandom) & 16'($urandom) & 16'($urandom)));
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		idling = 1;
		quiet_cycles = 0;
		in_ch.valid = 0;
		in_ch.operation = OP_CAST;
		in_ch.column = '0;
		in_ch.row_index = '0;
		in_ch.row_cells = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// empty map: every ray walks off the map, center column has a zero y component; then a boxed map
		cast(11'd0);
		cast(11'd540);
		cast(11'd1079);
		cast(11'd2047);
		boxed_map();
		cast(11'd0);
		cast(11'd540);
		cast(11'd1079);
		cast(11'd1500);
		drain();

		// player on a grid line facing an adjacent wall: zero distance
		set_view(20'h30000, 20'h38000, 20'hF0000, 20'h0, 20'h0, 20'h10000);
		load_row(4'd3, 16'h0004);
		cast(11'd540);
		cast(11'd100);
		load_row(4'd15, 16'h0000);
		load_row(4'd0, 16'hFFFF);
		cast(11'd900);
		drain();

		// extreme vectors and corner positions
		set_view(20'h00000, 20'hFFFFF, 20'h20000, 20'h1FFFF, 20'h1FFFF, 20'h20000);
		cast(11'd0);
		cast(11'd1079);
		cast(11'd2047);
		drain();

		for (int phase = 0; phase < 10; phase++) begin
			if (phase == 9) idling = 0;
			set_view(rand_pos(), rand_pos(), rand_vec(), rand_vec(), rand_vec(), rand_vec());
			if ($urandom_range(0, 2) != 0) boxed_map();
			for (int k = 0; k < 110; k++) begin
				if ($urandom_range(0, 5) == 0)
					load_row(4'($urandom), 16'($urandom) & 16'($urandom));
				else if ($urandom_range(0, 9) == 0)
					cast(11'($urandom));
				else
					cast(11'($urandom_range(0, SCREEN_WIDTH - 1)));
			end
			drain();
		end

		drain();
		if (slices.errors == 0 && slices.pending.size() == 0)
			$display("grid_ray_caster_unit test passed");
		else
			$display("grid_ray_caster_unit test failed");
		$finish;
	end
endmodule
